@@ src/pfc_pkg.sv @@
// ----------------------------------------------------------------------------
// pfc_pkg
// Format codes, register indexes and constants of the pixel format converter
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pfc_pkg;

  localparam int unsigned PIX_W = 32;
  localparam int unsigned FMT_W = 3;
  localparam int unsigned CFG_IDX_W = 2;

  typedef enum logic [FMT_W-1:0] {
    FMT_Y1       = 3'd0,
    FMT_Y2       = 3'd1,
    FMT_Y4       = 3'd2,
    FMT_Y8       = 3'd3,
    FMT_RGB565   = 3'd4,
    FMT_RGB888   = 3'd5,
    FMT_ARGB8888 = 3'd6,
    FMT_RGBA8888 = 3'd7
  } fmt_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SOURCE_FORMAT = 2'd0,
    CFG_TARGET_FORMAT = 2'd1
  } cfg_idx_e;

  // floor(s / 3) == (s * 683) >> 11 for every channel sum up to 765
  localparam logic [9:0] DIV3_MUL   = 10'd683;
  localparam int unsigned DIV3_SHIFT = 11;

  typedef struct packed {
    fmt_e source_format;
    fmt_e target_format;
  } fmt_cfg_t;

endpackage

`default_nettype wire

@@ src/pfc_in_if.sv @@
// ----------------------------------------------------------------------------
// pfc_in_if
// Source pixel word channel: valid, ready and the source pixel
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface pfc_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] pixel_in;

  modport source (output valid, output pixel_in, input ready);
  modport sink   (input valid, input pixel_in, output ready);
endinterface

`default_nettype wire

@@ src/pfc_out_if.sv @@
// ----------------------------------------------------------------------------
// pfc_out_if
// Converted pixel word channel: valid, ready and the result pixel
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface pfc_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] pixel_out;

  modport source (output valid, output pixel_out, input ready);
  modport sink   (input valid, input pixel_out, output ready);
endinterface

`default_nettype wire

@@ src/pfc_convert.sv @@
// ----------------------------------------------------------------------------
// pfc_convert
// Expands one pixel word to 8-bit channels and repacks it in the target format
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pfc_convert (
  input  wire pfc_pkg::fmt_cfg_t cfg_i,
  input  wire logic [31:0]       pixel_i,
  output logic      [31:0]       pixel_o
);

  logic [7:0]  r;
  logic [7:0]  g;
  logic [7:0]  b;
  logic [7:0]  a;
  logic [7:0]  lvl;
  logic [7:0]  v;
  logic [7:0]  v2;
  logic [9:0]  sum;
  logic [19:0] prod;
  logic [7:0]  y;

  // gray level
  always_comb begin
    v  = pixel_i[7:0];
    v2 = v | {v[5:0], 2'b00};
    case (cfg_i.source_format)
      pfc_pkg::FMT_Y1: lvl = (pixel_i != 32'd0) ? 8'hff : 8'h00;
      pfc_pkg::FMT_Y2: lvl = v2 | {v2[3:0], 4'b0000};
      pfc_pkg::FMT_Y4: lvl = v | {v[3:0], 4'b0000};
      default:         lvl = v;
    endcase
  end

  // unpack
  always_comb begin
    a = 8'hff;
    case (cfg_i.source_format)
      pfc_pkg::FMT_RGB565: begin
        r = {pixel_i[15:11], pixel_i[15:13]};
        g = {pixel_i[10:5], pixel_i[10:9]};
        b = {pixel_i[4:0], pixel_i[4:2]};
      end
      pfc_pkg::FMT_RGB888: begin
        r = pixel_i[23:16];
        g = pixel_i[15:8];
        b = pixel_i[7:0];
      end
      pfc_pkg::FMT_ARGB8888: begin
        a = pixel_i[31:24];
        r = pixel_i[23:16];
        g = pixel_i[15:8];
        b = pixel_i[7:0];
      end
      pfc_pkg::FMT_RGBA8888: begin
        r = pixel_i[31:24];
        g = pixel_i[23:16];
        b = pixel_i[15:8];
        a = pixel_i[7:0];
      end
      default: begin
        r = lvl;
        g = lvl;
        b = lvl;
      end
    endcase
  end

  // truncated mean of the three colour channels
  always_comb begin
    sum  = {2'b00, r} + {2'b00, g} + {2'b00, b};
    prod = {10'd0, sum} * {10'd0, pfc_pkg::DIV3_MUL};
    y    = prod[pfc_pkg::DIV3_SHIFT +: 8];
  end

  // repack
  always_comb begin
    case (cfg_i.target_format)
      pfc_pkg::FMT_Y1:       pixel_o = {31'd0, y[7]};
      pfc_pkg::FMT_Y2:       pixel_o = {30'd0, y[7:6]};
      pfc_pkg::FMT_Y4:       pixel_o = {28'd0, y[7:4]};
      pfc_pkg::FMT_Y8:       pixel_o = {24'd0, y};
      pfc_pkg::FMT_RGB565:   pixel_o = {16'd0, r[7:3], g[7:2], b[7:3]};
      pfc_pkg::FMT_RGB888:   pixel_o = {8'd0, r, g, b};
      pfc_pkg::FMT_ARGB8888: pixel_o = {a, r, g, b};
      default:               pixel_o = {r, g, b, a};
    endcase
  end

endmodule

`default_nettype wire

@@ src/pixel_format_converter_top.sv @@
// ----------------------------------------------------------------------------
// pixel_format_converter_top
// Streaming pixel format converter between gray, RGB565 and 32-bit colour
// ----------------------------------------------------------------------------
//   channel   dir  handshake      payload
//   pix_i     in   valid/ready    pixel_in  [31:0]
//   pix_o     out  valid/ready    pixel_out [31:0]
//   cfg       in   cfg_we_i       cfg_idx_i [1:0], cfg_data_i [2:0]
//
// one word per clock while pix_o is not stalled; input register then result register
// the channel sum and divide by three sit between the two registers
// reset clears the valid flags and sets both formats to Y1
// a stall at pix_o fills both registers, then pix_i.ready drops
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pixel_format_converter_top (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [pfc_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [pfc_pkg::FMT_W-1:0]     cfg_data_i,
  pfc_in_if.sink                              pix_i,
  pfc_out_if.source                           pix_o
);

  pfc_pkg::fmt_cfg_t cfg_q;
  logic              in_vld_q;
  logic [31:0]       in_pix_q;
  logic              out_vld_q;
  logic [31:0]       out_pix_q;
  logic [31:0]       conv_pix;
  logic              out_rdy;
  logic              in_rdy;

  // format registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.source_format <= pfc_pkg::FMT_Y1;
      cfg_q.target_format <= pfc_pkg::FMT_Y1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        pfc_pkg::CFG_SOURCE_FORMAT: cfg_q.source_format <= pfc_pkg::fmt_e'(cfg_data_i);
        pfc_pkg::CFG_TARGET_FORMAT: cfg_q.target_format <= pfc_pkg::fmt_e'(cfg_data_i);
        default: ;
      endcase
    end
  end

  assign out_rdy     = !out_vld_q || pix_o.ready;
  assign in_rdy      = !in_vld_q || out_rdy;
  assign pix_i.ready = in_rdy;

  // input word register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_rdy) begin
      in_vld_q <= pix_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_rdy && pix_i.valid) begin
      in_pix_q <= pix_i.pixel_in;
    end
  end

  pfc_convert u_convert (
    .cfg_i   (cfg_q),
    .pixel_i (in_pix_q),
    .pixel_o (conv_pix)
  );

  // result word register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_rdy) begin
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_rdy && in_vld_q) begin
      out_pix_q <= conv_pix;
    end
  end

  assign pix_o.valid     = out_vld_q;
  assign pix_o.pixel_out = out_pix_q;

  // a held input word moves on once the result register is free
  a_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_vld_q && out_rdy |=> out_vld_q)
    else $error("input word not moved to result register");

  // with the result register free, a new word is always taken
  a_no_bubble: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_vld_q |-> in_rdy)
    else $error("input blocked while result register empty");

  // one-bit gray target leaves the upper bits clear
  a_y1_pack: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_q.target_format == pfc_pkg::FMT_Y1 |-> conv_pix[31:1] == 31'd0)
    else $error("Y1 word has stray upper bits");

  // rgb888 target leaves the top byte clear
  a_rgb888_pack: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_q.target_format == pfc_pkg::FMT_RGB888 |-> conv_pix[31:24] == 8'd0)
    else $error("RGB888 word has a nonzero top byte");

endmodule

`default_nettype wire

@@ tb/pixel_format_checker.sv @@
// ----------------------------------------------------------------------------
// pixel_format_checker
// Watches the pixel channels and the register port of the format converter,
// works out each converted word from the live format settings and compares
// the block's output words in order against the expected ones
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pixel_format_checker (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [pfc_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [pfc_pkg::FMT_W-1:0]     cfg_data_i,
  pfc_in_if                                   pix_i,
  pfc_out_if                                  pix_o,
  output int                                  pending_o,
  output int                                  mismatches_o
);

  import pfc_pkg::*;

  localparam int MAX_PRINTED = 40;

  typedef struct {
    logic [PIX_W-1:0] word;
    fmt_e             src;
    fmt_e             dst;
    logic [PIX_W-1:0] pixel;
  } converted_word_t;

  fmt_e            src_fmt;
  fmt_e            dst_fmt;
  converted_word_t converted_q[$];
  converted_word_t oldest;
  int              mismatch_count = 0;

  assign mismatches_o = mismatch_count;

  // level of a gray source word, stray high bits of the low byte kept
  function automatic logic [7:0] gray_level(input fmt_e fmt, input logic [PIX_W-1:0] w);
    logic [7:0] v;
    v = w[7:0];
    case (fmt)
      FMT_Y1: v = (w != '0) ? 8'hff : 8'h00;
      FMT_Y2: begin
        v = v | (v << 2);
        v = v | (v << 4);
      end
      FMT_Y4: v = v | (v << 4);
      default: ;
    endcase
    return v;
  endfunction

  function automatic logic [PIX_W-1:0] convert_pixel(input fmt_e src, input fmt_e dst,
                                                     input logic [PIX_W-1:0] w);
    logic [7:0]       r;
    logic [7:0]       g;
    logic [7:0]       b;
    logic [7:0]       a;
    logic [7:0]       y;
    logic [9:0]       sum;
    logic [PIX_W-1:0] res;
    a = 8'hff;
    case (src)
      FMT_RGB565: begin
        r = {w[15:11], w[15:13]};
        g = {w[10:5], w[10:9]};
        b = {w[4:0], w[4:2]};
      end
      FMT_RGB888: begin
        r = w[23:16];
        g = w[15:8];
        b = w[7:0];
      end
      FMT_ARGB8888: begin
        a = w[31:24];
        r = w[23:16];
        g = w[15:8];
        b = w[7:0];
      end
      FMT_RGBA8888: begin
        r = w[31:24];
        g = w[23:16];
        b = w[15:8];
        a = w[7:0];
      end
      default: begin
        r = gray_level(src, w);
        g = r;
        b = r;
      end
    endcase
    sum = 10'(r) + 10'(g) + 10'(b);
    y   = 8'(sum / 10'd3);
    case (dst)
      FMT_Y1:       res = {31'b0, y[7]};
      FMT_Y2:       res = {30'b0, y[7:6]};
      FMT_Y4:       res = {28'b0, y[7:4]};
      FMT_Y8:       res = {24'b0, y};
      FMT_RGB565:   res = {16'b0, r[7:3], g[7:2], b[7:3]};
      FMT_RGB888:   res = {8'b0, r, g, b};
      FMT_ARGB8888: res = {a, r, g, b};
      default:      res = {r, g, b, a};
    endcase
    return res;
  endfunction

  task automatic report_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTED) begin
      $display("mismatch at %0t: %s", $time, what);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_fmt   <= FMT_Y1;
      dst_fmt   <= FMT_Y1;
      pending_o <= 0;
      converted_q.delete();
    end else begin
      if (pix_o.valid && pix_o.ready) begin
        if (converted_q.size() == 0) begin
          report_mismatch($sformatf("output word %08h with none outstanding", pix_o.pixel_out));
        end else begin
          oldest = converted_q.pop_front();
          if (pix_o.pixel_out !== oldest.pixel) begin
            report_mismatch($sformatf("%s to %s of %08h gave %08h, expected %08h",
                                      oldest.src.name(), oldest.dst.name(), oldest.word,
                                      pix_o.pixel_out, oldest.pixel));
          end
        end
      end
      if (pix_i.valid && pix_i.ready) begin
        converted_q.push_back('{pix_i.pixel_in, src_fmt, dst_fmt,
                                convert_pixel(src_fmt, dst_fmt, pix_i.pixel_in)});
      end
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_SOURCE_FORMAT) begin
          src_fmt <= fmt_e'(cfg_data_i);
        end else if (cfg_idx_i == CFG_TARGET_FORMAT) begin
          dst_fmt <= fmt_e'(cfg_data_i);
        end
      end
      pending_o <= converted_q.size();
    end
  end

endmodule

`default_nettype wire

@@ tb/pixel_format_converter_top_test.sv @@
// ----------------------------------------------------------------------------
// pixel_format_converter_top_test
// Drives the pixel format converter with directed corner words and then
// random words under every source/target format pair, with random input gaps
// and output stalls; the checker beside the block does all the comparing
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pixel_format_converter_top_test;

  import pfc_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;
  localparam int unsigned          IDLE_PCT    = 11;
  localparam int                   NUM_PAIRS   = 64;
  localparam int                   STEADY_LO   = 24;
  localparam int                   STEADY_HI   = 32;
  localparam int                   DRAIN_PAIR  = 40;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [FMT_W-1:0]     cfg_data_i;
  logic                 steady;
  int                   pending;
  int                   mismatches;
  int unsigned          words_sent = 0;
  int unsigned          directed_words;

  pfc_in_if  pix_in_bus ();
  pfc_out_if pix_out_bus ();

  pixel_format_converter_top uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .pix_i      (pix_in_bus),
    .pix_o      (pix_out_bus)
  );

  pixel_format_checker u_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .pix_i        (pix_in_bus),
    .pix_o        (pix_out_bus),
    .pending_o    (pending),
    .mismatches_o (mismatches)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #1_000_000;
    $display("FAIL");
    $finish;
  end

  // output side stalls
  initial begin
    pix_out_bus.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      pix_out_bus.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  function automatic logic [PIX_W-1:0] random_pixel();
    logic [PIX_W-1:0] w;
    case ($urandom_range(9))
      0: w = '0;
      1: w = '1;
      2: w = PIX_W'($urandom_range(8'hff));
      3: w = PIX_W'($urandom_range(16'hffff));
      4: w = PIX_W'(1) << $urandom_range(PIX_W - 1);
      default: w = $urandom();
    endcase
    return w;
  endfunction

  task automatic send_word(input logic [PIX_W-1:0] word);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      pix_in_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    pix_in_bus.valid    <= 1'b1;
    pix_in_bus.pixel_in <= word;
    @(posedge clk_i);
    while (!pix_in_bus.ready) @(posedge clk_i);
    words_sent++;
  endtask

  // stop sending and wait for every outstanding word
  task automatic settle();
    pix_in_bus.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [FMT_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_formats(input fmt_e src, input fmt_e dst);
    settle();
    write_reg(CFG_SOURCE_FORMAT, src);
    write_reg(CFG_TARGET_FORMAT, dst);
  endtask

  initial begin
    int count;
    rst_ni = 1'b0;
    cfg_we_i            <= 1'b0;
    cfg_idx_i           <= CFG_SOURCE_FORMAT;
    cfg_data_i          <= FMT_Y1;
    pix_in_bus.valid    <= 1'b0;
    pix_in_bus.pixel_in <= '0;
    steady              <= 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // gray sources: y1 on any nonzero word, stray bits above the level width
    set_formats(FMT_Y1, FMT_Y8);
    send_word(32'h0000_0000);
    send_word(32'h0000_0001);
    send_word(32'h8000_0000);
    set_formats(FMT_Y2, FMT_Y8);
    send_word(32'h0000_0002);
    send_word(32'h0000_0003);
    send_word(32'hffff_ffff);
    set_formats(FMT_Y4, FMT_Y2);
    send_word(32'h0000_000f);
    send_word(32'h1234_56f5);
    // writes to unused indexes must leave both formats alone
    settle();
    write_reg(CFG_SPARE_2, FMT_RGBA8888);
    write_reg(CFG_SPARE_3, FMT_RGB565);
    send_word(32'h0000_0009);
    set_formats(FMT_Y8, FMT_Y1);
    send_word(32'hffff_ff7f);
    send_word(32'h0000_0080);
    // colour sources, ignored upper bits, alpha default
    set_formats(FMT_RGB565, FMT_RGB888);
    send_word(32'h0000_ffff);
    send_word(32'hffff_0000);
    send_word(32'h0000_f81f);
    set_formats(FMT_RGB888, FMT_ARGB8888);
    send_word(32'hff12_3456);
    send_word(32'h00ff_ffff);
    set_formats(FMT_ARGB8888, FMT_RGBA8888);
    send_word(32'h80ff_0001);
    set_formats(FMT_RGBA8888, FMT_RGB565);
    send_word(32'h1234_5678);
    send_word(32'hffff_ffff);
    // truncated mean
    set_formats(FMT_RGBA8888, FMT_Y4);
    send_word(32'hffff_ff00);
    send_word(32'h0101_0200);
    directed_words = words_sent;

    for (int pair = 0; pair < NUM_PAIRS; pair++) begin
      set_formats(fmt_e'(FMT_W'(pair / 8)), fmt_e'(FMT_W'(pair % 8)));
      steady <= (pair >= STEADY_LO) && (pair < STEADY_HI);
      count = $urandom_range(32, 20);
      for (int k = 0; k < count; k++) begin
        if (pair == DRAIN_PAIR && k == count / 2) begin
          settle();
        end
        send_word(random_pixel());
      end
    end

    settle();
    repeat (8) @(posedge clk_i);
    $display("%0d words converted, %0d directed corner words and the rest random over all %0d",
             words_sent, directed_words, NUM_PAIRS);
    $display("source/target pairs, with random gaps and stalls and one steady stretch");
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
